/* rtl/core/fca_pkg.sv */
// fca_pkg: constants, command and status codes, and shared structs for the
// FAT chain allocator. No dependencies.
package fca_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int LIVE          = (TABLE_ENTRIES < 255) ? TABLE_ENTRIES : 255;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

    localparam logic [7:0] END_MARK = 8'hFF;
    localparam logic [8:0] LIVE_N   = 9'(LIVE);
    localparam logic [8:0] LAST_IDX = 9'(TABLE_ENTRIES - 1);

    localparam logic [2:0] CMD_NEW    = 3'd0;
    localparam logic [2:0] CMD_SIZE   = 3'd1;
    localparam logic [2:0] CMD_APPEND = 3'd2;
    localparam logic [2:0] CMD_LOCATE = 3'd3;
    localparam logic [2:0] CMD_FORMAT = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [7:0] value;
    } fca_res_t;

endpackage

/* rtl/core/fca_ram.sv */
// fca_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module fca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/fca_seq.sv */
// fca_seq: command sequencer; walks directory and chain tables through the RAMs.
// Depends on fca_pkg.
module fca_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        command,
    input  logic [7:0]        file_index,
    input  logic [7:0]        location,
    output fca_pkg::ram_req_t dir_req,
    input  logic [7:0]        dir_rdata,
    output fca_pkg::ram_req_t nxt_req,
    input  logic [7:0]        nxt_rdata,
    output fca_pkg::fca_res_t res,
    input  logic              res_take
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_NEW_CHK, S_SIZE_DIR, S_WALK, S_AP_DIR, S_AP_FIN,
        S_AP_NUM, S_AP_W1, S_AP_W2, S_LOC_DIR, S_LOC_STEP, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [7:0] num_reg, num_next;
    logic [7:0] loc_reg, loc_next;
    logic [8:0] f_reg, f_next;
    logic [8:0] best_reg, best_next;
    logic       any_reg, any_next;
    logic       phase_reg, phase_next;
    logic [7:0] cur_reg, cur_next;
    logic [8:0] steps_reg, steps_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       fmt_reg, fmt_next;
    logic [8:0] idx_reg, idx_next;
    logic       dir_oob_reg, dir_oob_next;
    logic       nxt_oob_reg, nxt_oob_next;
    logic [1:0] rstat_reg, rstat_next;
    logic [7:0] rval_reg, rval_next;

    logic [7:0] dir_d, walk_n, dir_rval, nxt_rval;
    logic [7:0] dir_waddr_v, nxt_waddr_v, dir_wdata, nxt_wdata;
    logic       dir_we, nxt_we, clr;
    logic [7:0] lc;
    logic [7:0] lk;
    logic [8:0] b;

    assign dir_d  = dir_oob_reg ? fca_pkg::END_MARK : dir_rdata;
    assign walk_n = nxt_oob_reg ? fca_pkg::END_MARK : nxt_rdata;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        num_next     = num_reg;
        loc_next     = loc_reg;
        f_next       = f_reg;
        best_next    = best_reg;
        any_next     = any_reg;
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        cnt_next     = cnt_reg;
        fmt_next     = fmt_reg;
        idx_next     = idx_reg;
        rstat_next   = rstat_reg;
        rval_next    = rval_reg;
        dir_rval     = 8'd0;
        nxt_rval     = 8'd0;
        dir_we       = 1'b0;
        nxt_we       = 1'b0;
        dir_waddr_v  = num_reg;
        dir_wdata    = best_reg[7:0];
        nxt_waddr_v  = cur_reg;
        nxt_wdata    = best_reg[7:0];
        clr          = 1'b0;
        lc           = 8'd0;
        lk           = 8'd0;
        b            = 9'd0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr      = 1'b1;
                idx_next = idx_reg + 9'd1;
                if (idx_reg == fca_pkg::LAST_IDX)
                begin
                    fmt_next = 1'b0;
                    if (fmt_reg)
                    begin
                        rstat_next = fca_pkg::ST_OK;
                        rval_next  = 8'd0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    num_next = file_index;
                    loc_next = location;
                    rstat_next = fca_pkg::ST_FAIL;
                    rval_next  = fca_pkg::END_MARK;
                    case (command)
                        fca_pkg::CMD_NEW:
                        begin
                            f_next     = 9'd0;
                            state_next = S_NEW_CHK;
                        end
                        fca_pkg::CMD_SIZE:
                        begin
                            dir_rval   = file_index;
                            state_next = S_SIZE_DIR;
                        end
                        fca_pkg::CMD_APPEND:
                        begin
                            if ({1'b0, file_index} >= fca_pkg::LIVE_N)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                f_next     = 9'd0;
                                best_next  = 9'd0;
                                any_next   = 1'b0;
                                phase_next = 1'b0;
                                state_next = S_AP_DIR;
                            end
                        end
                        fca_pkg::CMD_LOCATE:
                        begin
                            dir_rval   = file_index;
                            cnt_next   = 8'd0;
                            state_next = S_LOC_DIR;
                        end
                        fca_pkg::CMD_FORMAT:
                        begin
                            idx_next   = 9'd0;
                            fmt_next   = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_NEW_CHK:
            begin
                if (dir_d == fca_pkg::END_MARK)
                begin
                    rstat_next = fca_pkg::ST_OK;
                    rval_next  = f_reg[7:0];
                    state_next = S_DONE;
                end
                else if (f_reg + 9'd1 >= fca_pkg::LIVE_N)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    f_next   = f_reg + 9'd1;
                    dir_rval = f_next[7:0];
                end
            end
            S_SIZE_DIR:
            begin
                if (dir_d == fca_pkg::END_MARK)
                begin
                    rstat_next = fca_pkg::ST_OK;
                    rval_next  = 8'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = dir_d;
                    steps_next = 9'd0;
                    nxt_rval   = dir_d;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_n != fca_pkg::END_MARK && steps_reg + 9'd1 >= fca_pkg::LIVE_N)
                begin
                    // chain loops or runs past the table
                    rstat_next = fca_pkg::ST_CORRUPT;
                    state_next = S_DONE;
                end
                else if (walk_n != fca_pkg::END_MARK)
                begin
                    cur_next   = walk_n;
                    steps_next = steps_reg + 9'd1;
                    nxt_rval   = walk_n;
                end
                else if (cmd_reg == fca_pkg::CMD_SIZE)
                begin
                    rstat_next = fca_pkg::ST_OK;
                    rval_next  = 8'(steps_reg + 9'd1);
                    state_next = S_DONE;
                end
                else if (!phase_reg)
                begin
                    if (!any_reg || {1'b0, cur_reg} > best_reg)
                    begin
                        best_next = {1'b0, cur_reg};
                    end
                    any_next = 1'b1;
                    if (f_reg + 9'd1 >= fca_pkg::LIVE_N)
                    begin
                        state_next = S_AP_FIN;
                    end
                    else
                    begin
                        f_next     = f_reg + 9'd1;
                        dir_rval   = f_next[7:0];
                        state_next = S_AP_DIR;
                    end
                end
                else
                begin
                    state_next = S_AP_W1;
                end
            end
            S_AP_DIR:
            begin
                if (dir_d == fca_pkg::END_MARK)
                begin
                    state_next = S_AP_FIN;
                end
                else
                begin
                    cur_next   = dir_d;
                    steps_next = 9'd0;
                    nxt_rval   = dir_d;
                    state_next = S_WALK;
                end
            end
            S_AP_FIN:
            begin
                b = any_reg ? best_reg + 9'd1 : 9'd0;
                if (b >= fca_pkg::LIVE_N)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    best_next  = b;
                    dir_rval   = num_reg;
                    state_next = S_AP_NUM;
                end
            end
            S_AP_NUM:
            begin
                if (dir_d == fca_pkg::END_MARK)
                begin
                    dir_we     = 1'b1;
                    state_next = S_AP_W2;
                end
                else
                begin
                    phase_next = 1'b1;
                    cur_next   = dir_d;
                    steps_next = 9'd0;
                    nxt_rval   = dir_d;
                    state_next = S_WALK;
                end
            end
            S_AP_W1:
            begin
                // link old tail; a tail beyond the live range reads as end anyway
                nxt_we     = ({1'b0, cur_reg} < fca_pkg::LIVE_N);
                state_next = S_AP_W2;
            end
            S_AP_W2:
            begin
                nxt_we      = 1'b1;
                nxt_waddr_v = best_reg[7:0];
                nxt_wdata   = fca_pkg::END_MARK;
                rstat_next  = fca_pkg::ST_OK;
                rval_next   = best_reg[7:0];
                state_next  = S_DONE;
            end
            S_LOC_DIR, S_LOC_STEP:
            begin
                lc = (state_reg == S_LOC_DIR) ? dir_d : walk_n;
                lk = (state_reg == S_LOC_DIR) ? cnt_reg : cnt_reg + 8'd1;
                cur_next = lc;
                cnt_next = lk;
                if (lk < loc_reg && lc != fca_pkg::END_MARK)
                begin
                    nxt_rval   = lc;
                    state_next = S_LOC_STEP;
                end
                else if (lc == fca_pkg::END_MARK)
                begin
                    state_next = S_DONE;
                end
                else if ({1'b0, loc_reg} >= fca_pkg::LIVE_N)
                begin
                    rstat_next = fca_pkg::ST_CORRUPT;
                    state_next = S_DONE;
                end
                else
                begin
                    rstat_next = fca_pkg::ST_OK;
                    rval_next  = lc;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign dir_oob_next = ({1'b0, dir_rval} >= fca_pkg::LIVE_N);
    assign nxt_oob_next = ({1'b0, nxt_rval} >= fca_pkg::LIVE_N);

    always_comb
    begin
        dir_req.raddr = dir_rval[fca_pkg::ADDR_W-1:0];
        nxt_req.raddr = nxt_rval[fca_pkg::ADDR_W-1:0];
        if (clr)
        begin
            dir_req.we    = 1'b1;
            dir_req.waddr = idx_reg[fca_pkg::ADDR_W-1:0];
            dir_req.wdata = fca_pkg::END_MARK;
            nxt_req.we    = 1'b1;
            nxt_req.waddr = idx_reg[fca_pkg::ADDR_W-1:0];
            nxt_req.wdata = fca_pkg::END_MARK;
        end
        else
        begin
            dir_req.we    = dir_we;
            dir_req.waddr = dir_waddr_v[fca_pkg::ADDR_W-1:0];
            dir_req.wdata = dir_wdata;
            nxt_req.we    = nxt_we;
            nxt_req.waddr = nxt_waddr_v[fca_pkg::ADDR_W-1:0];
            nxt_req.wdata = nxt_wdata;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.status = rstat_reg;
    assign res.value  = rval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            fmt_reg     <= 1'b0;
            idx_reg     <= 9'd0;
            dir_oob_reg <= 1'b0;
            nxt_oob_reg <= 1'b0;
            cmd_reg     <= fca_pkg::CMD_NEW;
            num_reg     <= 8'd0;
            loc_reg     <= 8'd0;
            f_reg       <= 9'd0;
            best_reg    <= 9'd0;
            any_reg     <= 1'b0;
            phase_reg   <= 1'b0;
            cur_reg     <= 8'd0;
            steps_reg   <= 9'd0;
            cnt_reg     <= 8'd0;
            rstat_reg   <= fca_pkg::ST_OK;
            rval_reg    <= 8'd0;
        end
        else
        begin
            state_reg   <= state_next;
            fmt_reg     <= fmt_next;
            idx_reg     <= idx_next;
            dir_oob_reg <= dir_oob_next;
            nxt_oob_reg <= nxt_oob_next;
            cmd_reg     <= cmd_next;
            num_reg     <= num_next;
            loc_reg     <= loc_next;
            f_reg       <= f_next;
            best_reg    <= best_next;
            any_reg     <= any_next;
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            steps_reg   <= steps_next;
            cnt_reg     <= cnt_next;
            rstat_reg   <= rstat_next;
            rval_reg    <= rval_next;
        end
    end

endmodule

/* rtl/core/fat_chain_allocator.sv */
// fat_chain_allocator: top level; directory and chain RAMs, sequencer, result register.
// Depends on fca_pkg, fca_ram, fca_seq.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_stall, command,          | in / out(stall)
//          | file_index, location                  |
//  output  | out_valid, out_stall, status, value   | out / in(stall)
//
// One transaction at a time; reads are registered, a table lookup per cycle in a walk.
// new file: scans the directory for a free entry; size/locate: walk the file's chain.
// append: scans directory entries and chain links, then walks the target file's chain.
// format and reset: a clearing pass over all TABLE_ENTRIES (256) entries writing 255;
// no input transaction is taken during it.
// The result register frees the sequencer while a result waits on out_stall.
module fat_chain_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic [7:0] file_index,
    input  logic [7:0] location,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] value
);

    fca_pkg::ram_req_t dir_req, nxt_req;
    fca_pkg::fca_res_t res;
    logic [7:0]        dir_rdata, nxt_rdata;
    logic              res_take;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg;
    logic [7:0] value_reg;

    // directory: first sector of each file
    fca_ram #(.WIDTH(8), .DEPTH(fca_pkg::TABLE_ENTRIES)) u_dir (
        .clk   (clk),
        .we    (dir_req.we),
        .waddr (dir_req.waddr),
        .wdata (dir_req.wdata),
        .raddr (dir_req.raddr),
        .rdata (dir_rdata)
    );

    // chain table: next sector of each sector
    fca_ram #(.WIDTH(8), .DEPTH(fca_pkg::TABLE_ENTRIES)) u_nxt (
        .clk   (clk),
        .we    (nxt_req.we),
        .waddr (nxt_req.waddr),
        .wdata (nxt_req.wdata),
        .raddr (nxt_req.raddr),
        .rdata (nxt_rdata)
    );

    fca_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .file_index  (file_index),
        .location    (location),
        .dir_req     (dir_req),
        .dir_rdata   (dir_rdata),
        .nxt_req     (nxt_req),
        .nxt_rdata   (nxt_rdata),
        .res         (res),
        .res_take    (res_take)
    );

    // slot is free when empty or being drained this cycle
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
        begin
            status_reg <= res.status;
            value_reg  <= res.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

endmodule

/* dv/tb_fat_chain_allocator.sv */
`timescale 1ns / 100ps
// tb_fat_chain_allocator: self-checking testbench for the FAT chain allocator.
// Depends on fca_pkg and the fat_chain_allocator RTL; nothing else.
module tb_fat_chain_allocator;

    localparam int WATCHDOG_LIMIT = 200000;  // cycles without any transaction
    localparam int END_WAIT       = 600;     // covers a trailing format pass

    typedef struct {
        logic [1:0] status;
        logic [7:0] value;
    } fat_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] command = fca_pkg::CMD_NEW;
    logic [7:0] file_index = 8'd0;
    logic [7:0] location = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status;
    logic [7:0] value;

    // shadow copy of the directory and chain tables
    logic [7:0] dir_shadow [256];
    logic [7:0] chain_shadow [256];

    fat_result_t expected_results [$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int corrupt_seen = 0;
    int fail_seen = 0;
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    fat_chain_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .file_index (file_index),
        .location   (location),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .value      (value)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Shadow-table model
    // ---------------------------------------------------------------
    // Indexes at or past LIVE read as the end marker.
    function automatic logic [7:0] dir_at(int i);
        return (i >= fca_pkg::LIVE) ? fca_pkg::END_MARK : dir_shadow[i];
    endfunction

    function automatic logic [7:0] chain_at(int i);
        return (i >= fca_pkg::LIVE) ? fca_pkg::END_MARK : chain_shadow[i];
    endfunction

    // Follows a chain to its last sector; a walk of LIVE links flags a loop.
    function automatic logic [7:0] chain_tail(logic [7:0] start, output int links,
                                              output bit looped);
        logic [7:0] cur;
        logic [7:0] nxt;
        links = 0;
        looped = 0;
        cur = start;
        if (start == fca_pkg::END_MARK)
            return fca_pkg::END_MARK;
        forever
        begin
            nxt = chain_at(cur);
            if (nxt == fca_pkg::END_MARK)
                return cur;
            cur = nxt;
            links++;
            if (links >= fca_pkg::LIVE)
            begin
                looped = 1;
                return fca_pkg::END_MARK;
            end
        end
    endfunction

    function automatic void clear_shadow();
        foreach (dir_shadow[i])
        begin
            dir_shadow[i] = fca_pkg::END_MARK;
            chain_shadow[i] = fca_pkg::END_MARK;
        end
    endfunction

    // Applies one command to the shadow tables and returns the result it gives.
    function automatic fat_result_t apply_fat_command(logic [2:0] cmd, logic [7:0] fnum,
                                                      logic [7:0] loc);
        fat_result_t r;
        logic [7:0] cur;
        logic [7:0] last;
        logic [7:0] tail;
        int links;
        int best;
        bit looped;
        bit any;
        r.status = fca_pkg::ST_FAIL;
        r.value = fca_pkg::END_MARK;
        case (cmd)
            fca_pkg::CMD_NEW:
                for (int f = 0; f < fca_pkg::LIVE; f++)
                    if (dir_at(f) == fca_pkg::END_MARK)
                    begin
                        r.status = fca_pkg::ST_OK;
                        r.value = 8'(f);
                        break;
                    end
            fca_pkg::CMD_SIZE:
            begin
                cur = dir_at(fnum);
                if (cur == fca_pkg::END_MARK)
                begin
                    r.status = fca_pkg::ST_OK;
                    r.value = 8'd0;
                end
                else
                begin
                    void'(chain_tail(cur, links, looped));
                    if (looped)
                        r.status = fca_pkg::ST_CORRUPT;
                    else
                    begin
                        r.status = fca_pkg::ST_OK;
                        r.value = 8'(links + 1);
                    end
                end
            end
            fca_pkg::CMD_APPEND:
                if (fnum < fca_pkg::LIVE)
                begin
                    // allocate one past the largest tail over the leading used files
                    best = 0;
                    any = 0;
                    looped = 0;
                    for (int f = 0; f < fca_pkg::LIVE; f++)
                    begin
                        last = chain_tail(dir_at(f), links, looped);
                        if (looped || last == fca_pkg::END_MARK)
                            break;
                        if (!any || last > best)
                            best = last;
                        any = 1;
                    end
                    if (looped)
                        r.status = fca_pkg::ST_CORRUPT;
                    else
                    begin
                        best = any ? best + 1 : 0;
                        if (best < fca_pkg::LIVE)
                        begin
                            cur = dir_at(fnum);
                            tail = fca_pkg::END_MARK;
                            if (cur != fca_pkg::END_MARK)
                                tail = chain_tail(cur, links, looped);
                            if (looped)
                                r.status = fca_pkg::ST_CORRUPT;
                            else
                            begin
                                if (cur == fca_pkg::END_MARK)
                                    dir_shadow[fnum] = 8'(best);
                                else
                                    chain_shadow[tail] = 8'(best);
                                chain_shadow[best] = fca_pkg::END_MARK;
                                r.status = fca_pkg::ST_OK;
                                r.value = 8'(best);
                            end
                        end
                    end
                end
            fca_pkg::CMD_LOCATE:
            begin
                cur = dir_at(fnum);
                for (int f = 0; f < loc && cur != fca_pkg::END_MARK; f++)
                    cur = chain_at(cur);
                if (cur != fca_pkg::END_MARK)
                begin
                    if (loc >= fca_pkg::LIVE)
                        r.status = fca_pkg::ST_CORRUPT;
                    else
                    begin
                        r.status = fca_pkg::ST_OK;
                        r.value = cur;
                    end
                end
            end
            fca_pkg::CMD_FORMAT:
            begin
                clear_shadow();
                r.status = fca_pkg::ST_OK;
                r.value = 8'd0;
            end
            default: ;  // unknown command: refused, tables untouched
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver side
    // ---------------------------------------------------------------
    // Offers one command; the shadow model is updated when it is taken.
    task automatic send_command(logic [2:0] cmd, logic [7:0] fnum, logic [7:0] loc);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        file_index <= fnum;
        location <= loc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_fat_command(cmd, fnum, loc));
        items_sent++;
    endtask

    // Sender stops offering until every outstanding result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall, optional long hold-off, result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        fat_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction: status %0d value %0d",
                                          status, value));
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              status, want.status));
                if (value !== want.value)
                    report_mismatch($sformatf("value got %0d expected %0d",
                                              value, want.value));
                if (want.status == fca_pkg::ST_CORRUPT)
                    corrupt_seen++;
                if (want.status == fca_pkg::ST_FAIL)
                    fail_seen++;
            end
            results_seen++;
        end
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Watchdog: any accepted transaction on either side resets the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Basic commands, empty files, end of chain, bad indexes, unknown codes.
    task automatic test_directed();
        send_command(fca_pkg::CMD_FORMAT, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_SIZE, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_LOCATE, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_NEW, 8'd0, 8'd0);
        for (int i = 0; i < 3; i++)
            send_command(fca_pkg::CMD_APPEND, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_SIZE, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_LOCATE, 8'd0, 8'd2);
        send_command(fca_pkg::CMD_LOCATE, 8'd0, 8'd3);       // past end
        send_command(fca_pkg::CMD_LOCATE, 8'd0, 8'd255);
        send_command(fca_pkg::CMD_NEW, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_APPEND, 8'd255, 8'd0);     // file out of range
        send_command(fca_pkg::CMD_APPEND, 8'd254, 8'd0);
        send_command(fca_pkg::CMD_SIZE, 8'd255, 8'd0);
        send_command(3'd5, 8'd0, 8'd0);
        send_command(3'd7, 8'd255, 8'd255);
        drain_results();
    endtask

    // Gap at file 0 lets two files share sector 0, then a self loop forms.
    task automatic test_corrupt_chain();
        send_command(fca_pkg::CMD_FORMAT, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_APPEND, 8'd5, 8'd0);
        send_command(fca_pkg::CMD_APPEND, 8'd6, 8'd0);
        send_command(fca_pkg::CMD_APPEND, 8'd5, 8'd0);
        send_command(fca_pkg::CMD_SIZE, 8'd5, 8'd0);
        send_command(fca_pkg::CMD_LOCATE, 8'd5, 8'd255);
        send_command(fca_pkg::CMD_LOCATE, 8'd5, 8'd254);
        send_command(fca_pkg::CMD_APPEND, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_APPEND, 8'd1, 8'd0);
        drain_results();
    endtask

    // Every file gets one sector until directory and disk are exhausted.
    task automatic test_full_disk();
        send_command(fca_pkg::CMD_FORMAT, 8'd0, 8'd0);
        for (int f = 0; f < fca_pkg::LIVE; f++)
            send_command(fca_pkg::CMD_APPEND, 8'(f), 8'd0);
        send_command(fca_pkg::CMD_NEW, 8'd0, 8'd0);
        send_command(fca_pkg::CMD_APPEND, 8'd3, 8'd0);
        send_command(fca_pkg::CMD_SIZE, 8'd254, 8'd0);
        send_command(fca_pkg::CMD_LOCATE, 8'd254, 8'd0);
        send_command(fca_pkg::CMD_FORMAT, 8'd0, 8'd0);
        drain_results();
    endtask

    // Mostly well-formed traffic on a few low files, some noise on top.
    task automatic test_random_traffic(int count);
        int pick;
        logic [2:0] cmd;
        logic [7:0] fnum;
        logic [7:0] loc;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)       cmd = fca_pkg::CMD_FORMAT;
            else if (pick < 4)  cmd = 3'($urandom_range(7, 5));
            else if (pick < 14) cmd = fca_pkg::CMD_NEW;
            else if (pick < 54) cmd = fca_pkg::CMD_APPEND;
            else if (pick < 69) cmd = fca_pkg::CMD_SIZE;
            else                cmd = fca_pkg::CMD_LOCATE;
            fnum = ($urandom_range(99) < 88) ? 8'($urandom_range(7)) : 8'($urandom);
            loc = ($urandom_range(99) < 85) ? 8'($urandom_range(12)) : 8'($urandom);
            send_command(cmd, fnum, loc);
        end
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering, so input stalls.
    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int n = 0; n < 8; n++)
            send_command(fca_pkg::CMD_APPEND, 8'($urandom_range(3)), 8'd0);
        send_command(fca_pkg::CMD_SIZE, 8'd1, 8'd0);
        drain_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        clear_shadow();

        test_directed();
        test_corrupt_chain();
        test_full_disk();

        in_idle_pct = 19;
        out_idle_pct = 76;
        test_random_traffic(480);
        test_backpressure();

        in_idle_pct = 76;
        out_idle_pct = 19;
        test_random_traffic(480);

        in_idle_pct = 0;
        out_idle_pct = 0;
        test_random_traffic(480);

        drain_results();
        repeat (END_WAIT) @(posedge clk);

        $display("covered %0d commands, %0d results (%0d refused, %0d corrupt walks)",
                 items_sent, results_seen, fail_seen, corrupt_seen);
        $display("under three idle mixes, a long receiver hold-off and a full disk");
        if (errors == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
